// File: sv/vcac_pkg.sv
package vcac_pkg;

   localparam logic [2:0] OP_ACQUIRE = 3'd0;
   localparam logic [2:0] OP_RELEASE = 3'd1;
   localparam logic [2:0] OP_FORK    = 3'd2;
   localparam logic [2:0] OP_JOIN    = 3'd3;
   localparam logic [2:0] OP_READ    = 3'd4;
   localparam logic [2:0] OP_WRITE   = 3'd5;
   localparam logic [2:0] OP_BEGIN   = 3'd6;
   localparam logic [2:0] OP_END     = 3'd7;

   localparam logic [1:0] CSR_THREAD_COUNT = 2'd0;
   localparam logic [1:0] CSR_LOCK_COUNT   = 2'd1;
   localparam logic [1:0] CSR_VAR_COUNT    = 2'd2;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DISP  = 3'd2;
   localparam logic [2:0] S_RD    = 3'd3;
   localparam logic [2:0] S_USE   = 3'd4;
   localparam logic [2:0] S_WB    = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam logic [7:0] DEPTH_MAX = 8'd255;

endpackage

// File: sv/vcac_vc_ops.sv
module vcac_vc_ops #(
   parameter int LANES = 4,
   parameter int BITS  = 32
) (
   input  logic [LANES-1:0][BITS-1:0] lhs,
   input  logic [LANES-1:0][BITS-1:0] rhs,
   input  logic [LANES-1:0]           mask,
   output logic                       le,
   output logic [LANES-1:0][BITS-1:0] mx
);

   // le: lhs <= rhs on every masked entry; mx: masked entrywise max, lhs elsewhere
   always_comb begin
      le = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         mx[i] = lhs[i];
         if (mask[i]) begin
            if (lhs[i] > rhs[i]) begin
               le = 1'b0;
            end else begin
               mx[i] = rhs[i];
            end
         end
      end
   end

endmodule

// File: sv/vcac_mem.sv
module vcac_mem #(
   parameter int DEPTH = 336,
   parameter int WIDTH = 131
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: sv/vector_clock_atomicity_checker.sv
// Conflict-serializability checker over a stream of trace events, one event per
// req transaction and exactly one rsp transaction per event. Thread clocks,
// transaction start clocks and nesting depths sit in registers; lock, write and
// per-thread read clocks with their last releaser/writer share one single-port-
// write, registered-read memory of MAX_LOCKS + MAX_VARS * (MAX_THREADS + 1) rows.
// After reset a clearing pass writes every row, one per cycle, and no event is
// taken until it ends. Fork, join, release, begin, halted and ignored events
// settle in dispatch; acquire reads its lock row, read reads the variable's write
// row and then writes its own read row, and write reads the write row and every
// other tracked thread's read row before it writes the write row. End walks every
// tracked row with a read-modify-write. The next event can be taken in the cycle
// its predecessor's result goes out; a result still waiting holds the block once
// the following event is done.
// Once a violation is flagged it holds, and later events answer halted.
module vector_clock_atomicity_checker #(
   parameter int MAX_THREADS = 4,
   parameter int MAX_LOCKS   = 16,
   parameter int MAX_VARS    = 64,
   parameter int CLOCK_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // op[2:0], thread[4:3], target[10:5]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // violation[0], halted[1]
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [6:0]  csr_wdata
);

   import vcac_pkg::*;

   localparam int MT   = MAX_THREADS;
   localparam int ML   = MAX_LOCKS;
   localparam int MV   = MAX_VARS;
   localparam int CB   = CLOCK_BITS;
   localparam int TIW  = $clog2(MT);
   localparam int OW   = $clog2(MT + 1);
   localparam int ROWS = ML + MV + MT * MV;
   localparam int AW   = $clog2(ROWS);
   localparam int SW   = $clog2(MT + 2);
   localparam int MXLV = (ML > MV) ? ML : MV;
   localparam int IW   = $clog2(MXLV + 1);
   localparam int RW   = OW + MT * CB;
   localparam logic [OW-1:0] NONE_MARK = OW'(MT);

   typedef logic [MT-1:0][CB-1:0] vc_type;
   typedef struct packed {
      logic [OW-1:0] owner;
      vc_type        clk;
   } row_type;

   function automatic logic [AW-1:0] lock_slot(input int l);
      return AW'(l);
   endfunction

   function automatic logic [AW-1:0] write_addr(input int x);
      return AW'(ML + x);
   endfunction

   function automatic logic [AW-1:0] read_addr(input int u, input int x);
      return AW'(ML + MV + u * MV + x);
   endfunction

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [2:0]    thr_cnt_ff;
   logic [4:0]    lock_cnt_ff;
   logic [6:0]    var_cnt_ff;
   vc_type        tc_ff [MT];
   vc_type        tc_in [MT];
   vc_type        ts_ff [MT];
   vc_type        ts_in [MT];
   logic [7:0]    dep_ff [MT];
   logic [7:0]    dep_in [MT];
   logic          vio_ff, vio_in;
   logic          flag_ff, flag_in;
   logic          halt_ff, halt_in;
   logic [2:0]    op_ff, op_in;
   logic [1:0]    thr_ff, thr_in;
   logic [5:0]    tg_ff, tg_in;
   logic          ph_ff, ph_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [SW-1:0] sub_ff, sub_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          res_vio_ff, res_vio_in;
   logic          res_halt_ff, res_halt_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [RW-1:0] mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [RW-1:0] mem_rdata;
   row_type       rd_row;

   int            thr_lim;
   int            lock_lim;
   int            var_lim;
   int            cur_u;
   logic [MT-1:0] mask;
   logic [TIW-1:0] t_idx;
   logic [TIW-1:0] tg_tidx;
   logic          thread_ok;
   logic          lock_ok;
   logic          var_ok;
   logic          tg_thr_ok;
   vc_type        cag_k;
   logic          cag_le;
   vc_type        cag_mx;
   logic          cag_flag;
   logic          walk_le;
   vc_type        walk_mx;
   vc_type        beg_vc;
   logic [MT-1:0] gate_le;
   logic [MT-1:0] chk_le;
   vc_type        lane_mx [MT];

   assign rd_row = row_type'(mem_rdata);

   always_comb begin
      thr_lim = (thr_cnt_ff == 3'd0) ? 1 : ((32'(thr_cnt_ff) > MT) ? MT : 32'(thr_cnt_ff));
      lock_lim = (32'(lock_cnt_ff) > ML) ? ML : 32'(lock_cnt_ff);
      var_lim  = (32'(var_cnt_ff) > MV) ? MV : 32'(var_cnt_ff);
      for (int i = 0; i < MT; i++) begin
         mask[i] = (i < thr_lim);
      end
      t_idx     = TIW'(thr_ff);
      tg_tidx   = TIW'(tg_ff);
      thread_ok = (32'(thr_ff) < thr_lim);
      lock_ok   = (32'(tg_ff) < lock_lim);
      var_ok    = (32'(tg_ff) < var_lim);
      tg_thr_ok = (32'(tg_ff) < thr_lim);
      cur_u     = 32'(sub_ff) - 1;
      cag_k     = (state_ff == S_DISP) ? tc_ff[tg_tidx] : rd_row.clk;
      beg_vc    = tc_ff[t_idx];
      if (beg_vc[t_idx] != {CB{1'b1}}) begin
         beg_vc[t_idx] = beg_vc[t_idx] + 1'b1;
      end
   end

   vcac_vc_ops #(.LANES(MT), .BITS(CB)) u_cag_le (
      .lhs (ts_ff[t_idx]),
      .rhs (cag_k),
      .mask(mask),
      .le  (cag_le),
      .mx  ()
   );

   vcac_vc_ops #(.LANES(MT), .BITS(CB)) u_cag_mx (
      .lhs (tc_ff[t_idx]),
      .rhs (cag_k),
      .mask(mask),
      .le  (),
      .mx  (cag_mx)
   );

   assign cag_flag = (dep_ff[t_idx] != 8'd0) && cag_le;

   vcac_vc_ops #(.LANES(MT), .BITS(CB)) u_walk_le (
      .lhs (ts_ff[t_idx]),
      .rhs (rd_row.clk),
      .mask(mask),
      .le  (walk_le),
      .mx  ()
   );

   vcac_vc_ops #(.LANES(MT), .BITS(CB)) u_walk_mx (
      .lhs (rd_row.clk),
      .rhs (tc_ff[t_idx]),
      .mask(mask),
      .le  (),
      .mx  (walk_mx)
   );

   for (genvar u = 0; u < MT; u++) begin : g_lane
      vcac_vc_ops #(.LANES(MT), .BITS(CB)) u_gate (
         .lhs (ts_ff[t_idx]),
         .rhs (tc_ff[u]),
         .mask(mask),
         .le  (gate_le[u]),
         .mx  ()
      );
      vcac_vc_ops #(.LANES(MT), .BITS(CB)) u_chk (
         .lhs (ts_ff[u]),
         .rhs (tc_ff[t_idx]),
         .mask(mask),
         .le  (chk_le[u]),
         .mx  ()
      );
      vcac_vc_ops #(.LANES(MT), .BITS(CB)) u_mx (
         .lhs (tc_ff[u]),
         .rhs (tc_ff[t_idx]),
         .mask(mask),
         .le  (),
         .mx  (lane_mx[u])
      );
   end

   vcac_mem #(.DEPTH(ROWS), .WIDTH(RW)) u_mem (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   // accesses to one row never overlap: each write lands before the next read issues
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      tc_in        = tc_ff;
      ts_in        = ts_ff;
      dep_in       = dep_ff;
      vio_in       = vio_ff;
      flag_in      = flag_ff;
      halt_in      = halt_ff;
      op_in        = op_ff;
      thr_in       = thr_ff;
      tg_in        = tg_ff;
      ph_in        = ph_ff;
      idx_in       = idx_ff;
      sub_in       = sub_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      res_vio_in   = res_vio_ff;
      res_halt_in  = res_halt_ff;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = '0;
      mem_raddr    = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = {NONE_MARK, {(MT * CB){1'b0}}};
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tdata[2:0];
               thr_in   = req_tdata[4:3];
               tg_in    = req_tdata[10:5];
               flag_in  = 1'b0;
               halt_in  = 1'b0;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_DONE;
            if (vio_ff) begin
               halt_in = 1'b1;
            end else if (thread_ok) begin
               case (op_ff)
                  OP_ACQUIRE: begin
                     if (lock_ok) begin
                        state_in = S_RD;
                     end
                  end
                  OP_RELEASE: begin
                     if (lock_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = lock_slot(32'(tg_ff));
                        mem_wdata = {OW'(t_idx), tc_ff[t_idx]};
                     end
                  end
                  OP_FORK: begin
                     if (tg_thr_ok) begin
                        tc_in[tg_tidx] = lane_mx[tg_tidx];
                     end
                  end
                  OP_JOIN: begin
                     if (tg_thr_ok) begin
                        if (cag_flag) begin
                           flag_in = 1'b1;
                        end
                        tc_in[t_idx] = cag_mx;
                     end
                  end
                  OP_READ, OP_WRITE: begin
                     if (var_ok) begin
                        sub_in   = '0;
                        state_in = S_RD;
                     end
                  end
                  OP_BEGIN: begin
                     tc_in[t_idx] = beg_vc;
                     ts_in[t_idx] = beg_vc;
                     if (dep_ff[t_idx] != DEPTH_MAX) begin
                        dep_in[t_idx] = dep_ff[t_idx] + 8'd1;
                     end
                  end
                  default: begin
                     if (dep_ff[t_idx] != 8'd0) begin
                        dep_in[t_idx] = dep_ff[t_idx] - 8'd1;
                     end
                     for (int u = 0; u < MT; u++) begin
                        if (u != 32'(t_idx) && mask[u] && gate_le[u]) begin
                           if (dep_ff[u] != 8'd0 && chk_le[u]) begin
                              flag_in = 1'b1;
                           end
                           tc_in[u] = lane_mx[u];
                        end
                     end
                     ph_in    = 1'b0;
                     idx_in   = '0;
                     sub_in   = '0;
                     state_in = S_RD;
                  end
               endcase
            end
         end
         S_RD: begin
            case (op_ff)
               OP_ACQUIRE: begin
                  mem_raddr = lock_slot(32'(tg_ff));
                  state_in  = S_USE;
               end
               OP_READ: begin
                  mem_raddr = write_addr(32'(tg_ff));
                  state_in  = S_USE;
               end
               OP_WRITE: begin
                  if (sub_ff == '0) begin
                     mem_raddr = write_addr(32'(tg_ff));
                     state_in  = S_USE;
                  end else if (cur_u >= thr_lim) begin
                     state_in = S_WB;
                  end else if (cur_u == 32'(t_idx)) begin
                     sub_in = sub_ff + 1'b1;
                  end else begin
                     mem_raddr = read_addr(cur_u, 32'(tg_ff));
                     state_in  = S_USE;
                  end
               end
               default: begin
                  if (!ph_ff) begin
                     if (32'(idx_ff) >= lock_lim) begin
                        ph_in  = 1'b1;
                        idx_in = '0;
                        sub_in = '0;
                     end else begin
                        mem_raddr = lock_slot(32'(idx_ff));
                        addr_in   = mem_raddr;
                        state_in  = S_USE;
                     end
                  end else if (32'(idx_ff) >= var_lim) begin
                     state_in = S_DONE;
                  end else if (sub_ff == '0) begin
                     mem_raddr = write_addr(32'(idx_ff));
                     addr_in   = mem_raddr;
                     state_in  = S_USE;
                  end else if (cur_u >= thr_lim) begin
                     idx_in = idx_ff + 1'b1;
                     sub_in = '0;
                  end else begin
                     mem_raddr = read_addr(cur_u, 32'(idx_ff));
                     addr_in   = mem_raddr;
                     state_in  = S_USE;
                  end
               end
            endcase
         end
         S_USE: begin
            case (op_ff)
               OP_ACQUIRE, OP_READ: begin
                  if (rd_row.owner != OW'(t_idx)) begin
                     if (cag_flag) begin
                        flag_in = 1'b1;
                     end
                     tc_in[t_idx] = cag_mx;
                  end
                  state_in = (op_ff == OP_READ) ? S_WB : S_DONE;
               end
               OP_WRITE: begin
                  if (sub_ff != '0 || rd_row.owner != OW'(t_idx)) begin
                     if (cag_flag) begin
                        flag_in = 1'b1;
                     end
                     tc_in[t_idx] = cag_mx;
                  end
                  sub_in   = sub_ff + 1'b1;
                  state_in = S_RD;
               end
               default: begin
                  if (walk_le) begin
                     mem_we    = 1'b1;
                     mem_waddr = addr_ff;
                     mem_wdata = {rd_row.owner, walk_mx};
                  end
                  if (!ph_ff) begin
                     idx_in = idx_ff + 1'b1;
                  end else begin
                     sub_in = sub_ff + 1'b1;
                  end
                  state_in = S_RD;
               end
            endcase
         end
         S_WB: begin
            mem_we = 1'b1;
            if (op_ff == OP_READ) begin
               mem_waddr = read_addr(32'(t_idx), 32'(tg_ff));
               mem_wdata = {NONE_MARK, tc_ff[t_idx]};
            end else begin
               mem_waddr = write_addr(32'(tg_ff));
               mem_wdata = {OW'(t_idx), tc_ff[t_idx]};
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               res_vio_in   = flag_ff;
               res_halt_in  = halt_ff;
               if (flag_ff) begin
                  vio_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         thr_cnt_ff   <= 3'd4;
         lock_cnt_ff  <= 5'd16;
         var_cnt_ff   <= 7'd64;
         vio_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MT; i++) begin
            tc_ff[i]    <= '0;
            tc_ff[i][i] <= CB'(1);
            ts_ff[i]    <= '0;
            dep_ff[i]   <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         vio_ff       <= vio_in;
         rsp_valid_ff <= rsp_valid_in;
         tc_ff        <= tc_in;
         ts_ff        <= ts_in;
         dep_ff       <= dep_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_THREAD_COUNT: thr_cnt_ff  <= csr_wdata[2:0];
               CSR_LOCK_COUNT:   lock_cnt_ff <= csr_wdata[4:0];
               CSR_VAR_COUNT:    var_cnt_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      flag_ff     <= flag_in;
      halt_ff     <= halt_in;
      op_ff       <= op_in;
      thr_ff      <= thr_in;
      tg_ff       <= tg_in;
      ph_ff       <= ph_in;
      idx_ff      <= idx_in;
      sub_ff      <= sub_in;
      addr_ff     <= addr_in;
      res_vio_ff  <= res_vio_in;
      res_halt_ff <= res_halt_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, res_halt_ff, res_vio_ff};

   a_vio_sticky: assert property (@(posedge clock) disable iff (reset)
      vio_ff |=> vio_ff)
      else $error("violation flag dropped");

   a_halt_needs_vio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_halt_ff |-> vio_ff)
      else $error("halted result without a standing violation");

   a_not_both: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(res_vio_ff && res_halt_ff))
      else $error("violation and halted in one result");

   a_use_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_USE |-> $past(state_ff) == S_RD)
      else $error("memory data used without a read issued");

endmodule
